// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/ip4rx_pkg.sv =====
// Types and constants of the IPv4 receive header checker.
package ip4rx_pkg;

   localparam int LEN_BITS      = 16;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_ADDR_BITS = 3;

   localparam int IDX_LEN_HI    = 2;
   localparam int IDX_LEN_LO    = 3;
   localparam int IDX_PROTO     = 9;
   localparam int IDX_CSUM_LO   = 11;
   localparam int IDX_SRC_FIRST = 12;
   localparam int IDX_SRC_LAST  = 15;
   localparam int IDX_DST_FIRST = 16;
   localparam int IDX_DST_LAST  = 19;

   localparam logic [3:0] VERDICT_TCP      = 4'd0;
   localparam logic [3:0] VERDICT_UDP      = 4'd1;
   localparam logic [3:0] VERDICT_OTHER    = 4'd2;
   localparam logic [3:0] VERDICT_SHORT    = 4'd3;
   localparam logic [3:0] VERDICT_VERSION  = 4'd4;
   localparam logic [3:0] VERDICT_IHL      = 4'd5;
   localparam logic [3:0] VERDICT_LENGTH   = 4'd6;
   localparam logic [3:0] VERDICT_CHECKSUM = 4'd7;
   localparam logic [3:0] VERDICT_NOT_OURS = 4'd8;

   localparam logic [7:0]          TCP_PROTOCOL = 8'd6;
   localparam logic [7:0]          UDP_PROTOCOL = 8'd17;
   localparam logic [3:0]          IP_VERSION   = 4'd4;
   localparam logic [3:0]          MIN_IHL      = 4'd5;
   localparam logic [LEN_BITS-1:0] MIN_FRAME    = 16'd20;
   localparam logic [31:0]         BROADCAST    = 32'hFFFF_FFFF;

   localparam logic REG_LOCAL_ADDR = 1'b0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_data_type;

   typedef struct packed {
      logic [3:0]  verdict;
      logic [31:0] source_address;
      logic [7:0]  protocol_id;
      logic [5:0]  header_bytes;
      logic [15:0] payload_bytes;
   } rsp_data_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] frame_len;
      logic [7:0]          first_byte;
      logic [15:0]         declared_len;
      logic [7:0]          protocol;
      logic [31:0]         sender;
      logic [31:0]         target;
      logic [15:0]         sum;
      logic [15:0]         rx_checksum;
   } summary_type;

endpackage

// ===== src/ip4rx_front.sv =====
// Front end: takes frame bytes, captures header fields and sums the header.
`include "assert_macros.svh"

module ip4rx_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  ip4rx_pkg::req_data_type req_data,
   input  logic                   queue_full,
   output logic                   queue_push,
   output ip4rx_pkg::summary_type queue_data
);
   import ip4rx_pkg::*;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]            first_ff, first_in;
   logic [15:0]           len_ff, len_in;
   logic [7:0]            proto_ff, proto_in;
   logic [31:0]           sender_ff, sender_in;
   logic [31:0]           target_ff, target_in;
   logic [15:0]           sum_ff, sum_in;
   logic [15:0]           rx_ff, rx_in;
   logic [7:0]            pend_ff, pend_in;

   logic                  accept;
   logic [7:0]            b;
   logic [5:0]            hl;
   logic [15:0]           word;
   logic [16:0]           sum_wide;
   logic [15:0]           sum_fold;

   always_comb begin
      accept    = req_push && !queue_full;
      b         = req_data.data_byte;
      first_in  = (count_ff == '0) ? b : first_ff;
      hl        = {first_in[3:0], 2'b00};
      len_in    = len_ff;
      proto_in  = proto_ff;
      sender_in = sender_ff;
      target_in = target_ff;
      sum_in    = sum_ff;
      rx_in     = rx_ff;
      pend_in   = pend_ff;
      word      = {pend_ff, b};
      sum_wide  = {1'b0, sum_ff} + {1'b0, word};
      sum_fold  = sum_wide[15:0] + {15'd0, sum_wide[16]};

      if (count_ff == COUNT_BITS'(IDX_LEN_HI)) begin
         len_in = {b, 8'h00};
      end else if (count_ff == COUNT_BITS'(IDX_LEN_LO)) begin
         len_in = {len_ff[15:8], b};
      end else if (count_ff == COUNT_BITS'(IDX_PROTO)) begin
         proto_in = b;
      end else if (count_ff >= COUNT_BITS'(IDX_SRC_FIRST) &&
                   count_ff <= COUNT_BITS'(IDX_SRC_LAST)) begin
         sender_in = {sender_ff[23:0], b};
      end else if (count_ff >= COUNT_BITS'(IDX_DST_FIRST) &&
                   count_ff <= COUNT_BITS'(IDX_DST_LAST)) begin
         target_in = {target_ff[23:0], b};
      end

      if (count_ff < COUNT_BITS'(hl)) begin
         if (!count_ff[0]) begin
            pend_in = b;
         end else if (count_ff == COUNT_BITS'(IDX_CSUM_LO)) begin
            rx_in = word;
         end else begin
            sum_in = sum_fold;
         end
      end

      count_in = (count_ff == '1) ? count_ff : count_ff + 1'b1;

      queue_push              = accept && req_data.last_byte;
      queue_data.frame_len    = LEN_BITS'(count_in);
      queue_data.first_byte   = first_in;
      queue_data.declared_len = len_in;
      queue_data.protocol     = proto_in;
      queue_data.sender       = sender_in;
      queue_data.target       = target_in;
      queue_data.sum          = sum_in;
      queue_data.rx_checksum  = rx_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last_byte)) begin
         count_ff  <= '0;
         first_ff  <= '0;
         len_ff    <= '0;
         proto_ff  <= '0;
         sender_ff <= '0;
         target_ff <= '0;
         sum_ff    <= '0;
         rx_ff     <= '0;
         pend_ff   <= '0;
      end else if (accept) begin
         count_ff  <= count_in;
         first_ff  <= first_in;
         len_ff    <= len_in;
         proto_ff  <= proto_in;
         sender_ff <= sender_in;
         target_ff <= target_in;
         sum_ff    <= sum_in;
         rx_ff     <= rx_in;
         pend_ff   <= pend_in;
      end
   end

   `ASSERT_CLK(a_count_cleared, queue_push |=> (count_ff == '0), "byte count not cleared after last word")
   `ASSERT_CLK(a_push_has_room, queue_push |-> !queue_full, "frame summary pushed into a full queue")

endmodule

// ===== src/ip4rx_queue.sv =====
// Short queue of frame summaries between the front and back ends.
`include "assert_macros.svh"

module ip4rx_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ip4rx_pkg::summary_type push_data,
   output logic                   full,
   input  logic                   pop,
   output ip4rx_pkg::summary_type pop_data,
   output logic                   empty
);
   import ip4rx_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   summary_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      pop_data  = entry_ff[rd_ptr_ff];
      wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_CLK(a_push_not_lost, (push && !pop && !full) |=> !empty, "queue empty after a push")

endmodule

// ===== src/ip4rx_back.sv =====
// Back end: turns a frame summary into a verdict and holds it for the receiver.
`include "assert_macros.svh"

module ip4rx_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            local_addr,
   input  logic                   queue_empty,
   input  ip4rx_pkg::summary_type queue_data,
   output logic                   queue_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output ip4rx_pkg::rsp_data_type rsp_data
);
   import ip4rx_pkg::*;

   logic         valid_ff;
   rsp_data_type data_ff, data_in;
   logic [5:0]   hl;
   logic [15:0]  hl16;
   logic [15:0]  frame_len;

   always_comb begin
      queue_pop = !queue_empty && (!valid_ff || rsp_pop);
      hl        = {queue_data.first_byte[3:0], 2'b00};
      hl16      = {10'd0, hl};
      frame_len = 16'(queue_data.frame_len);

      data_in.source_address = queue_data.sender;
      data_in.protocol_id    = queue_data.protocol;
      data_in.header_bytes   = hl;
      data_in.payload_bytes  = '0;

      if (frame_len < MIN_FRAME) begin
         data_in.verdict = VERDICT_SHORT;
      end else if (queue_data.first_byte[7:4] != IP_VERSION) begin
         data_in.verdict = VERDICT_VERSION;
      end else if (queue_data.first_byte[3:0] < MIN_IHL) begin
         data_in.verdict = VERDICT_IHL;
      end else if (queue_data.declared_len < hl16 || queue_data.declared_len > frame_len) begin
         data_in.verdict = VERDICT_LENGTH;
      end else if (~queue_data.sum != queue_data.rx_checksum) begin
         data_in.verdict = VERDICT_CHECKSUM;
      end else if (queue_data.target != local_addr && queue_data.target != BROADCAST &&
                   local_addr != '0) begin
         data_in.verdict = VERDICT_NOT_OURS;
      end else begin
         data_in.payload_bytes = queue_data.declared_len - hl16;
         if (queue_data.protocol == TCP_PROTOCOL) begin
            data_in.verdict = VERDICT_TCP;
         end else if (queue_data.protocol == UDP_PROTOCOL) begin
            data_in.verdict = VERDICT_UDP;
         end else begin
            data_in.verdict = VERDICT_OTHER;
         end
      end

      rsp_empty = !valid_ff;
      rsp_data  = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (queue_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         data_ff <= data_in;
      end
   end

   `ASSERT_CLK(a_verdict_range, valid_ff |-> (data_ff.verdict <= VERDICT_NOT_OURS), "verdict code out of range")
   `ASSERT_CLK(a_payload_on_reject, (valid_ff && data_ff.verdict > VERDICT_OTHER) |-> (data_ff.payload_bytes == '0), "payload length given on a rejected frame")

endmodule

// ===== src/ipv4_receive_header_checker_core.sv =====
// Top level of the IPv4 receive header checker.
//
// Frame bytes enter on the req_ channel, header first, one word per byte with
// last_byte set on the final byte of each frame. A word is taken at a clock
// edge where req_push is high and req_full is low; one byte per cycle is
// sustained while req_full stays low. The final byte of a frame yields one
// verdict word on the rsp_ channel, shown while rsp_empty is low and taken
// when rsp_pop is high. The front end writes each summary into a two-entry
// queue; the back end makes it a verdict in the output register once that
// register is empty or being read. The back end clears one summary per cycle
// while verdicts are taken, so a verdict can be taken every cycle. When the
// receiver stalls, the output register holds its word, the queue fills, and
// req_full then rises and stops all input until a verdict is taken. Reset
// clears the byte count, header state, queue, output valid flag and local
// address. The user must write the local address through the csr_ port only
// while no frame is in progress (not enforced). Zero accepts any destination.
module ipv4_receive_header_checker_core #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   input  ip4rx_pkg::req_data_type               req_data,
   output logic                                  req_full,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output ip4rx_pkg::rsp_data_type               rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ip4rx_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import ip4rx_pkg::*;

   logic [31:0] local_addr_ff;
   logic        reg_hit;
   logic        queue_push, queue_full, queue_pop, queue_empty;
   summary_type push_data, pop_data;

   always_comb begin
      reg_hit    = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_LOCAL_ADDR);
      csr_pready = 1'b1;
      csr_prdata = reg_hit ? local_addr_ff : 32'd0;
      req_full   = queue_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit) begin
         local_addr_ff <= csr_pwdata;
      end
   end

   ip4rx_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (push_data)
   );

   ip4rx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   ip4rx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .local_addr  (local_addr_ff),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .queue_pop   (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the IPv4 receive header checker: frames in, verdicts checked.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ip4rx_pkg::*;

   typedef logic [7:0] frame_bytes_type[$];

   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [CSR_ADDR_BITS-1:0] LOCAL_ADDR_OFFSET = {REG_LOCAL_ADDR, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   req_data_type req_data = '0;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_data_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   req_data_type pending_words[$];
   rsp_data_type expected_verdicts[$];
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit req_taken = 1'b0;

   logic [31:0] local_addr_cfg = '0;
   logic [15:0] frame_count = '0;
   logic [7:0] hdr_first = '0;
   logic [15:0] declared_total = '0;
   logic [7:0] proto_seen = '0;
   logic [31:0] src_seen = '0;
   logic [31:0] dst_seen = '0;
   logic [15:0] run_sum = '0;
   logic [15:0] rx_csum = '0;
   logic [7:0] high_half = '0;

   ipv4_receive_header_checker_core u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_data(req_data),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic logic [15:0] header_sum(frame_bytes_type f, int hl);
      logic [16:0] acc;
      logic [15:0] sum;
      int i;
      sum = '0;
      for (i = 0; i + 1 < hl && i + 1 < f.size(); i += 2) begin
         if (i != IDX_CSUM_LO - 1) begin
            acc = sum + {f[i], f[i + 1]};
            sum = acc[15:0] + acc[16];
         end
      end
      return sum;
   endfunction

   task automatic predict_word(input req_data_type w);
      logic [15:0] idx;
      logic [5:0] hl;
      logic [16:0] acc;
      rsp_data_type v;
      idx = frame_count;
      if (idx == 0) begin
         hdr_first = w.data_byte;
      end
      hl = {hdr_first[3:0], 2'b00};
      if (idx == IDX_LEN_HI) begin
         declared_total = {w.data_byte, 8'h00};
      end else if (idx == IDX_LEN_LO) begin
         declared_total = {declared_total[15:8], w.data_byte};
      end else if (idx == IDX_PROTO) begin
         proto_seen = w.data_byte;
      end else if (idx >= IDX_SRC_FIRST && idx <= IDX_SRC_LAST) begin
         src_seen = {src_seen[23:0], w.data_byte};
      end else if (idx >= IDX_DST_FIRST && idx <= IDX_DST_LAST) begin
         dst_seen = {dst_seen[23:0], w.data_byte};
      end
      if (idx < hl) begin
         if (!idx[0]) begin
            high_half = w.data_byte;
         end else if (idx == IDX_CSUM_LO) begin
            rx_csum = {high_half, w.data_byte};
         end else begin
            acc = run_sum + {high_half, w.data_byte};
            run_sum = acc[15:0] + acc[16];
         end
      end
      if (idx != 16'hFFFF) begin
         frame_count = idx + 16'd1;
      end
      if (w.last_byte) begin
         v = '0;
         v.source_address = src_seen;
         v.protocol_id = proto_seen;
         v.header_bytes = hl;
         if (frame_count < MIN_FRAME) begin
            v.verdict = VERDICT_SHORT;
         end else if (hdr_first[7:4] != IP_VERSION) begin
            v.verdict = VERDICT_VERSION;
         end else if (hdr_first[3:0] < MIN_IHL) begin
            v.verdict = VERDICT_IHL;
         end else if (declared_total < hl || declared_total > frame_count) begin
            v.verdict = VERDICT_LENGTH;
         end else if (16'(~run_sum) != rx_csum) begin
            v.verdict = VERDICT_CHECKSUM;
         end else if (dst_seen != local_addr_cfg && dst_seen != BROADCAST &&
                      local_addr_cfg != 0) begin
            v.verdict = VERDICT_NOT_OURS;
         end else begin
            v.payload_bytes = declared_total - hl;
            if (proto_seen == TCP_PROTOCOL) begin
               v.verdict = VERDICT_TCP;
            end else if (proto_seen == UDP_PROTOCOL) begin
               v.verdict = VERDICT_UDP;
            end else begin
               v.verdict = VERDICT_OTHER;
            end
         end
         expected_verdicts.push_back(v);
         frame_count = '0;
         hdr_first = '0;
         declared_total = '0;
         proto_seen = '0;
         src_seen = '0;
         dst_seen = '0;
         run_sum = '0;
         rx_csum = '0;
         high_half = '0;
      end
   endtask

   always @(posedge clock) begin
      req_taken = !reset && req_push && !req_full;
      if (req_taken) begin
         predict_word(pending_words.pop_front());
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!(req_push && !req_taken)) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_push <= 1'b1;
            req_data <= pending_words[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_verdicts.size() == 0) begin
            $error("verdict word taken with none expected");
            fail_count++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("verdict", want.verdict, rsp_data.verdict);
            check_field("source_address", want.source_address, rsp_data.source_address);
            check_field("protocol_id", want.protocol_id, rsp_data.protocol_id);
            check_field("header_bytes", want.header_bytes, rsp_data.header_bytes);
            check_field("payload_bytes", want.payload_bytes, rsp_data.payload_bytes);
         end
      end
   end

   task automatic queue_frame(input frame_bytes_type f);
      req_data_type w;
      int i;
      for (i = 0; i < f.size(); i++) begin
         w.data_byte = f[i];
         w.last_byte = (i == f.size() - 1);
         pending_words.push_back(w);
      end
   endtask

   task automatic set_declared(inout frame_bytes_type f, input logic [15:0] value);
      f[IDX_LEN_HI] = value[15:8];
      f[IDX_LEN_LO] = value[7:0];
   endtask

   task automatic build_frame(input logic [3:0] version, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [31:0] src,
                              input logic [31:0] dst, input int pay_len,
                              input bit zero_sum, output frame_bytes_type f);
      int hdr_len;
      int i;
      logic [15:0] word;
      hdr_len = (ihl < MIN_IHL) ? 20 : ihl * 4;
      f = {};
      for (i = 0; i < hdr_len + pay_len; i++) begin
         f.push_back(8'($urandom));
      end
      f[0] = {version, ihl};
      set_declared(f, 16'(ihl * 4 + pay_len));
      f[IDX_PROTO] = proto;
      for (i = 0; i < 4; i++) begin
         f[IDX_SRC_FIRST + i] = src[31 - 8 * i -: 8];
         f[IDX_DST_FIRST + i] = dst[31 - 8 * i -: 8];
      end
      f[IDX_CSUM_LO - 1] = 8'h00;
      f[IDX_CSUM_LO] = 8'h00;
      if (zero_sum) begin
         // Pick the identification word so that the folded sum is all ones.
         f[4] = 8'h00;
         f[5] = 8'h00;
         word = 16'hFFFF - header_sum(f, ihl * 4);
         f[4] = word[15:8];
         f[5] = word[7:0];
      end
      word = ~header_sum(f, ihl * 4);
      f[IDX_CSUM_LO - 1] = word[15:8];
      f[IDX_CSUM_LO] = word[7:0];
   endtask

   task automatic add_random_frame(output int nbytes);
      frame_bytes_type f;
      int kind;
      int pay;
      logic [3:0] ihl;
      logic [7:0] proto;
      logic [31:0] dst;
      logic [15:0] tl;
      kind = $urandom_range(99);
      ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : MIN_IHL;
      case ($urandom_range(3))
         0: proto = TCP_PROTOCOL;
         1: proto = UDP_PROTOCOL;
         default: proto = 8'($urandom);
      endcase
      case ($urandom_range(3))
         0: dst = local_addr_cfg;
         1: dst = BROADCAST;
         2: dst = $urandom;
         default: dst = local_addr_cfg ^ (32'h1 << $urandom_range(31));
      endcase
      pay = ($urandom_range(7) == 0) ? $urandom_range(200) : $urandom_range(12);
      build_frame(IP_VERSION, ihl, proto, $urandom, dst, pay, $urandom_range(15) == 0, f);
      if (kind < 60) begin
      end else if (kind < 65) begin
         f[0] = {IP_VERSION ^ 4'($urandom_range(15, 1)), f[0][3:0]};
      end else if (kind < 70) begin
         f[0] = {f[0][7:4], 4'($urandom_range(4))};
      end else if (kind < 75) begin
         tl = {f[IDX_LEN_HI], f[IDX_LEN_LO]} + 16'($urandom_range(1, 8));
         set_declared(f, tl);
      end else if (kind < 78) begin
         set_declared(f, 16'($urandom_range(ihl * 4 - 1)));
      end else if (kind < 85) begin
         f[$urandom_range(ihl * 4 - 1)] ^= 8'h01 << $urandom_range(7);
      end else if (kind < 90) begin
         repeat ($urandom_range(1, f.size() - 1)) f.pop_back();
      end else if (kind < 95) begin
         repeat ($urandom_range(1, 6)) f.push_back(8'($urandom));
      end else begin
         f = {};
         repeat ($urandom_range(1, 40)) f.push_back(8'($urandom));
      end
      queue_frame(f);
      nbytes = f.size();
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_local_addr(input logic [31:0] value);
      drain();
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = LOCAL_ADDR_OFFSET;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      local_addr_cfg = value;
      @(negedge clock);
      csr_psel = 1'b1;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      check_field("local_addr", value, csr_prdata);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   initial begin
      frame_bytes_type f;
      logic [31:0] phase_addr[4];
      int phase_idle[4];
      int phase_stall[4];
      int p;
      int nbytes;
      int phase_bytes;
      int phase_frames;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      build_frame(IP_VERSION, MIN_IHL, TCP_PROTOCOL, 32'h0A00_0001, 32'h0A00_0002, 0, 0, f);
      queue_frame(f);
      build_frame(IP_VERSION, 4'd15, UDP_PROTOCOL, 32'hFFFF_FFFF, 32'h0000_0000, 8, 0, f);
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, 8'hFF, 32'h0000_0000, 32'h1234_5678, 3, 0, f);
      queue_frame(f);
      f = {};
      f.push_back(8'hFF);
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, TCP_PROTOCOL, $urandom, $urandom, 0, 0, f);
      while (f.size() > 19) f.pop_back();
      queue_frame(f);
      build_frame(4'd6, MIN_IHL, TCP_PROTOCOL, $urandom, $urandom, 2, 0, f);
      queue_frame(f);
      build_frame(IP_VERSION, 4'd0, UDP_PROTOCOL, $urandom, $urandom, 2, 0, f);
      queue_frame(f);
      build_frame(IP_VERSION, 4'd4, UDP_PROTOCOL, $urandom, $urandom, 2, 0, f);
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, TCP_PROTOCOL, $urandom, $urandom, 4, 0, f);
      set_declared(f, 16'd19);
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, TCP_PROTOCOL, $urandom, $urandom, 4, 0, f);
      f.pop_back();
      queue_frame(f);
      // Header cut off well before its stated length.
      build_frame(IP_VERSION, 4'd15, TCP_PROTOCOL, $urandom, $urandom, 0, 0, f);
      while (f.size() > 40) f.pop_back();
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, UDP_PROTOCOL, $urandom, $urandom, 1, 0, f);
      f[IDX_CSUM_LO] ^= 8'h01;
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, TCP_PROTOCOL, $urandom, $urandom, 1, 1, f);
      queue_frame(f);
      // All-ones received checksum against a computed zero must fail.
      f[IDX_CSUM_LO - 1] = 8'hFF;
      f[IDX_CSUM_LO] = 8'hFF;
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, UDP_PROTOCOL, $urandom, $urandom, 2, 0, f);
      repeat (3) f.push_back(8'($urandom));
      queue_frame(f);
      f = {};
      repeat (25) f.push_back(8'hFF);
      queue_frame(f);
      f = {};
      repeat (25) f.push_back(8'h00);
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, TCP_PROTOCOL, $urandom, $urandom, 4, 0, f);
      set_declared(f, 16'd0);
      queue_frame(f);

      write_local_addr(32'hC0A8_0001);
      build_frame(IP_VERSION, MIN_IHL, TCP_PROTOCOL, $urandom, 32'hC0A8_0001, 5, 0, f);
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, UDP_PROTOCOL, $urandom, BROADCAST, 5, 0, f);
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, TCP_PROTOCOL, $urandom, 32'hC0A8_0002, 5, 0, f);
      queue_frame(f);

      write_local_addr(32'hFFFF_FFFF);
      build_frame(IP_VERSION, MIN_IHL, TCP_PROTOCOL, $urandom, BROADCAST, 0, 0, f);
      queue_frame(f);
      build_frame(IP_VERSION, MIN_IHL, UDP_PROTOCOL, $urandom, 32'h0000_0000, 0, 0, f);
      queue_frame(f);

      phase_addr = '{$urandom | 32'h1, 32'h0000_0000, 32'h0000_0001, $urandom};
      phase_idle = '{0, 66, 0, 29};
      phase_stall = '{0, 0, 66, 29};
      for (p = 0; p < 4; p++) begin
         write_local_addr(phase_addr[p]);
         send_idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         phase_bytes = 0;
         phase_frames = 0;
         while (phase_bytes < 160 || phase_frames < 4) begin
            add_random_frame(nbytes);
            phase_bytes += nbytes;
            phase_frames++;
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/ip4rx_pkg.sv
src/ip4rx_front.sv
src/ip4rx_queue.sv
src/ip4rx_back.sv
src/ipv4_receive_header_checker_core.sv
tb/testbench.sv
